### hdl/linear_probe_hash_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lpht: check failed");
`define LPHT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpht: implication failed");
`else
`define LPHT_ASSERT_ALWAYS(label, clk, rst, expr)
`define LPHT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

### hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, codes and word types of the hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SIZE  = 1024;
   localparam int SLOT_BITS   = $clog2(TABLE_SIZE);
   localparam int COUNT_BITS  = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] FILL_LIMIT_RESET = COUNT_BITS'(768);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;
   localparam logic [2:0] ST_FOUND    = 3'd5;
   localparam logic [2:0] ST_ABSENT   = 3'd6;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] key;
      logic [31:0]        value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [31:0]          key;
      logic [31:0]          value;
      logic [SLOT_BITS-1:0] home;
   } cmd_entry_type;

   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } job_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_status_type;

   typedef struct packed {
      logic        occupied;
      logic        tombstone;
      logic [31:0] key;
      logic [31:0] value;
   } slot_type;

   localparam int SLOT_WIDTH = $bits(slot_type);

endpackage

### hdl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing hash table with linear probing over a slot memory.
//
//   Channel   Ports                          Moves
//   request   req_push, req_full, req_word   command word
//   response  rsp_empty, rsp_pop, rsp_word   status word
//   control   csr_valid, csr_ready, csr_data fill limit word
//
// A search, remove or insert probes from the home slot onward (1 to 1024 slots);
// an insert rejected at the fill limit finishes without probing.
// A clear writes every slot, one slot per cycle through the write port.
// After reset a pass over all 1024 slots empties the slot memory with req_full high.
// A two-word queue holds commands while the prober works or the result waits.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_macros.svh"

module linear_probe_hash_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  lpht_pkg::req_word_type              req_word,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output lpht_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpht_pkg::COUNT_BITS-1:0]     csr_data
);

   logic [lpht_pkg::COUNT_BITS-1:0] fill_limit_ff, fill_limit_in;
   lpht_pkg::job_type               job;
   lpht_pkg::back_status_type       back_status;

   assign csr_ready     = 1'b1;
   assign fill_limit_in = (csr_valid && csr_ready) ? csr_data : fill_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_limit_ff <= lpht_pkg::FILL_LIMIT_RESET;
      end else begin
         fill_limit_ff <= fill_limit_in;
      end
   end

   lpht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .back_status(back_status),
      .job        (job)
   );

   lpht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .back_status(back_status),
      .fill_limit (fill_limit_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

   `LPHT_ASSERT_IMPLY(a_init_pass_blocks, clock, reset, $past(reset), req_full)
   `LPHT_ASSERT_IMPLY(a_count_in_range, clock, reset, !rsp_empty,
      rsp_word.entry_count <= lpht_pkg::COUNT_BITS'(lpht_pkg::TABLE_SIZE))
   `LPHT_ASSERT_IMPLY(a_insert_counts, clock, reset,
      !rsp_empty && (rsp_word.status == lpht_pkg::ST_INSERTED),
      rsp_word.entry_count != '0)
   `LPHT_ASSERT_ALWAYS(a_status_code, clock, reset,
      rsp_empty || (rsp_word.status != 3'd7))

endmodule

### hdl/lpht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hdl/lpht_front.sv
// ----------------------------------------------------------------------------
// Linear probe hash table front end
// Accepts command words, computes the home slot and queues them.
// ----------------------------------------------------------------------------
module lpht_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  lpht_pkg::req_word_type   req_word,
   input  lpht_pkg::back_status_type back_status,
   output lpht_pkg::job_type        job
);

   lpht_pkg::cmd_entry_type        entries_ff [lpht_pkg::QUEUE_DEPTH];
   lpht_pkg::cmd_entry_type        new_entry;
   logic [lpht_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lpht_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lpht_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic [lpht_pkg::SLOT_BITS-1:0] low_bits;
   logic                           push_ok;
   logic                           pop_ok;

   // The magnitude modulo a power-of-two table size is the low bits of the magnitude.
   assign low_bits = req_word.key[lpht_pkg::SLOT_BITS-1:0];

   always_comb begin
      new_entry.command = req_word.command;
      new_entry.key     = req_word.key;
      new_entry.value   = req_word.value;
      new_entry.home    = req_word.key[31] ? (~low_bits + lpht_pkg::SLOT_BITS'(1)) : low_bits;
   end

   assign req_full = back_status.init_busy ||
                     (count_ff == lpht_pkg::QCNT_BITS'(lpht_pkg::QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = back_status.pop && (count_ff != '0);

   assign job.valid = (count_ff != '0);
   assign job.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == lpht_pkg::QPTR_BITS'(lpht_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + lpht_pkg::QPTR_BITS'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == lpht_pkg::QPTR_BITS'(lpht_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + lpht_pkg::QPTR_BITS'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + lpht_pkg::QCNT_BITS'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - lpht_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

### hdl/lpht_back.sv
// ----------------------------------------------------------------------------
// Linear probe hash table back end
// Probes the slot memory one slot per cycle and holds the result word.
// ----------------------------------------------------------------------------
module lpht_back (
   input  logic                                clock,
   input  logic                                reset,
   input  lpht_pkg::job_type                   job,
   output lpht_pkg::back_status_type           back_status,
   input  logic [lpht_pkg::COUNT_BITS-1:0]     fill_limit,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output lpht_pkg::rsp_word_type              rsp_word
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_CLEAR = 2'd2;

   localparam logic [lpht_pkg::SLOT_BITS-1:0] LAST_SLOT =
      lpht_pkg::SLOT_BITS'(lpht_pkg::TABLE_SIZE - 1);

   logic [1:0]                      state_ff, state_in;
   lpht_pkg::cmd_entry_type         op_ff, op_in;
   logic [lpht_pkg::SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [lpht_pkg::SLOT_BITS-1:0]  steps_ff, steps_in;
   logic                            free_found_ff, free_found_in;
   logic [lpht_pkg::SLOT_BITS-1:0]  free_slot_ff, free_slot_in;
   logic [lpht_pkg::COUNT_BITS-1:0] live_ff, live_in;
   logic [lpht_pkg::SLOT_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic                            clr_reply_ff, clr_reply_in;
   logic                            out_valid_ff, out_valid_in;
   lpht_pkg::rsp_word_type          out_word_ff, out_word_in;

   logic                            ram_we;
   logic [lpht_pkg::SLOT_BITS-1:0]  ram_waddr;
   logic [lpht_pkg::SLOT_BITS-1:0]  ram_raddr;
   logic [lpht_pkg::SLOT_WIDTH-1:0] ram_wdata;
   logic [lpht_pkg::SLOT_WIDTH-1:0] ram_rdata;
   lpht_pkg::slot_type              rd_slot;
   lpht_pkg::slot_type              wr_slot;

   logic                            finish;
   logic [2:0]                      fin_status;
   logic                            job_pop;
   logic                            out_free;
   logic                            slot_empty;
   logic                            slot_hit;
   logic                            slot_tomb;
   logic [lpht_pkg::SLOT_BITS-1:0]  next_idx;

   lpht_ram #(
      .WIDTH(lpht_pkg::SLOT_WIDTH),
      .DEPTH(lpht_pkg::TABLE_SIZE)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_slot    = lpht_pkg::slot_type'(ram_rdata);
   assign ram_wdata  = lpht_pkg::SLOT_WIDTH'(wr_slot);
   assign slot_empty = !rd_slot.occupied;
   assign slot_tomb  = rd_slot.occupied && rd_slot.tombstone;
   assign slot_hit   = rd_slot.occupied && !rd_slot.tombstone && (rd_slot.key == op_ff.key);
   assign next_idx   = (idx_ff == LAST_SLOT) ? '0 : idx_ff + lpht_pkg::SLOT_BITS'(1);
   assign out_free   = !out_valid_ff || rsp_pop;

   assign back_status.pop       = job_pop;
   assign back_status.init_busy = (state_ff == S_CLEAR) && !clr_reply_ff;
   assign rsp_empty             = !out_valid_ff;
   assign rsp_word              = out_word_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      steps_in      = steps_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      live_in       = live_ff;
      clr_addr_in   = clr_addr_ff;
      clr_reply_in  = clr_reply_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_raddr     = idx_ff;
      wr_slot       = '0;
      finish        = 1'b0;
      fin_status    = lpht_pkg::ST_ABSENT;
      job_pop       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (job.valid && out_free) begin
               job_pop       = 1'b1;
               op_in         = job.entry;
               idx_in        = job.entry.home;
               steps_in      = '0;
               free_found_in = 1'b0;
               ram_raddr     = job.entry.home;
               if (job.entry.command == lpht_pkg::CMD_CLEAR) begin
                  state_in     = S_CLEAR;
                  clr_addr_in  = '0;
                  clr_reply_in = 1'b1;
               end else if ((job.entry.command == lpht_pkg::CMD_INSERT) &&
                            (live_ff >= fill_limit)) begin
                  finish     = 1'b1;
                  fin_status = lpht_pkg::ST_REJECTED;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (slot_empty) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               if (op_ff.command == lpht_pkg::CMD_INSERT) begin
                  ram_we     = 1'b1;
                  ram_waddr  = free_found_ff ? free_slot_ff : idx_ff;
                  wr_slot    = '{occupied: 1'b1, tombstone: 1'b0,
                                 key: op_ff.key, value: op_ff.value};
                  live_in    = live_ff + lpht_pkg::COUNT_BITS'(1);
                  fin_status = lpht_pkg::ST_INSERTED;
               end
            end else if (slot_hit) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff.command)
                  lpht_pkg::CMD_INSERT: begin
                     ram_we     = 1'b1;
                     wr_slot    = '{occupied: 1'b1, tombstone: 1'b0,
                                    key: rd_slot.key, value: op_ff.value};
                     fin_status = lpht_pkg::ST_UPDATED;
                  end
                  lpht_pkg::CMD_REMOVE: begin
                     ram_we     = 1'b1;
                     wr_slot    = '{occupied: 1'b1, tombstone: 1'b1,
                                    key: rd_slot.key, value: rd_slot.value};
                     live_in    = live_ff - lpht_pkg::COUNT_BITS'(1);
                     fin_status = lpht_pkg::ST_REMOVED;
                  end
                  default: begin
                     fin_status = lpht_pkg::ST_FOUND;
                  end
               endcase
            end else begin
               if (slot_tomb && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = idx_ff;
               end
               if (steps_ff == LAST_SLOT) begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
                  if (op_ff.command == lpht_pkg::CMD_INSERT) begin
                     if (free_found_ff || slot_tomb) begin
                        ram_we     = 1'b1;
                        ram_waddr  = free_found_ff ? free_slot_ff : idx_ff;
                        wr_slot    = '{occupied: 1'b1, tombstone: 1'b0,
                                       key: op_ff.key, value: op_ff.value};
                        live_in    = live_ff + lpht_pkg::COUNT_BITS'(1);
                        fin_status = lpht_pkg::ST_INSERTED;
                     end else begin
                        fin_status = lpht_pkg::ST_FULL;
                     end
                  end
               end else begin
                  idx_in    = next_idx;
                  steps_in  = steps_ff + lpht_pkg::SLOT_BITS'(1);
                  ram_raddr = next_idx;
               end
            end
         end
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + lpht_pkg::SLOT_BITS'(1);
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
               live_in  = '0;
               finish   = clr_reply_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff && !rsp_pop;
      out_word_in  = out_word_ff;
      if (finish) begin
         out_valid_in            = 1'b1;
         out_word_in.status      = fin_status;
         out_word_in.entry_count = live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         live_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         live_ff      <= live_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      steps_ff      <= steps_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      out_word_ff   <= out_word_in;
   end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Linear probe hash table unit testbench
// Drives insert, search, remove and clear words into the hash table, predicts
// every status word from a slot-accurate table model held by a scoreboard,
// and checks the words in order under random sender and receiver idling.
// The run covers collisions, wrap-around, tombstone reuse, the fill limit
// and a completely full table.
// ----------------------------------------------------------------------------
module testbench;
   import lpht_pkg::*;

   localparam int RUN_LIMIT   = 8_000_000;
   localparam int HOLD_CYCLES = 300;

   class table_scoreboard;
      bit           occupied [TABLE_SIZE];
      bit           tombstone [TABLE_SIZE];
      logic [31:0]  slot_key [TABLE_SIZE];
      int           live_count;
      int           fill_limit;
      int           mismatches;
      rsp_word_type expected_status [$];

      function new();
         fill_limit = int'(FILL_LIMIT_RESET);
         mismatches = 0;
         wipe_table();
      endfunction

      function void wipe_table();
         foreach (occupied[i]) begin
            occupied[i] = 1'b0;
            tombstone[i] = 1'b0;
         end
         live_count = 0;
      endfunction

      function int home_of(logic [31:0] key);
         logic [31:0] mag;
         mag = key[31] ? (~key + 32'd1) : key;
         return int'(mag % TABLE_SIZE);
      endfunction

      function int locate(logic [31:0] key);
         int idx;
         int i;
         idx = home_of(key);
         for (i = 0; i < TABLE_SIZE; i++) begin
            if (!occupied[idx]) return -1;
            if (!tombstone[idx] && slot_key[idx] == key) return idx;
            idx = (idx + 1) % TABLE_SIZE;
         end
         return -1;
      endfunction

      function logic [2:0] insert_key(logic [31:0] key);
         int idx;
         int free_idx;
         int i;
         if (live_count >= fill_limit) return ST_REJECTED;
         idx = home_of(key);
         free_idx = -1;
         for (i = 0; i < TABLE_SIZE; i++) begin
            if (!occupied[idx]) begin
               if (free_idx < 0) free_idx = idx;
               break;
            end
            if (tombstone[idx]) begin
               if (free_idx < 0) free_idx = idx;
            end else if (slot_key[idx] == key) begin
               return ST_UPDATED;
            end
            idx = (idx + 1) % TABLE_SIZE;
         end
         if (free_idx < 0) return ST_FULL;
         slot_key[free_idx] = key;
         occupied[free_idx] = 1'b1;
         tombstone[free_idx] = 1'b0;
         live_count++;
         return ST_INSERTED;
      endfunction

      function void note_command(req_word_type w);
         rsp_word_type want;
         logic [2:0]   st;
         int           idx;
         case (w.command)
            CMD_INSERT: st = insert_key(w.key);
            CMD_SEARCH: st = (locate(w.key) >= 0) ? ST_FOUND : ST_ABSENT;
            CMD_REMOVE: begin
               idx = locate(w.key);
               if (idx >= 0) begin
                  tombstone[idx] = 1'b1;
                  live_count--;
                  st = ST_REMOVED;
               end else begin
                  st = ST_ABSENT;
               end
            end
            default: begin
               wipe_table();
               st = ST_ABSENT;
            end
         endcase
         want.status = st;
         want.entry_count = COUNT_BITS'(live_count);
         expected_status.push_back(want);
      endfunction

      function void check_status(rsp_word_type got);
         rsp_word_type want;
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected word, status %0d count %0d", $time, got.status,
                     got.entry_count);
            mismatches++;
            return;
         end
         want = expected_status.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
         end
         if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry count expected %0d actual %0d", $time, want.entry_count,
                     got.entry_count);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   req_word_type          req_word;
   logic                  rsp_empty;
   logic                  rsp_pop;
   rsp_word_type          rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data;

   table_scoreboard board = new();
   int              words_sent = 0;
   int              words_checked = 0;
   int              cycle_count = 0;
   int              push_idle_pct = 29;
   int              pop_idle_pct = 76;
   logic [31:0]     key_pool [$];
   logic [31:0]     fill_keys [$];

   linear_probe_hash_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] key_at_home(input int h);
      logic [31:0] mag;
      mag = $urandom & 32'h7FFF_FFFF;
      mag = mag - (mag % TABLE_SIZE) + h;
      return $urandom_range(1) ? (~mag + 32'd1) : mag;
   endfunction

   task automatic send_word(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [31:0] value);
      req_word_type w;
      w.command = cmd;
      w.key = key;
      w.value = value;
      if (words_sent < 480) begin
         push_idle_pct = 29;
         pop_idle_pct = 76;
      end else if (words_sent < 960) begin
         push_idle_pct = 76;
         pop_idle_pct = 29;
      end else begin
         push_idle_pct = 0;
         pop_idle_pct = 0;
      end
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      board.note_command(w);
      words_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (board.expected_status.size() != 0);
   endtask

   task automatic write_limit(input int lim);
      drain();
      csr_valid <= 1'b1;
      csr_data <= COUNT_BITS'(lim);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      board.fill_limit = lim;
   endtask

   task automatic run_directed();
      send_word(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000);
      send_word(CMD_REMOVE, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
      send_word(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
      send_word(CMD_INSERT, 32'hFFFF_FC00, $urandom);
      send_word(CMD_INSERT, 32'h8000_0000, 32'h5555_5555);
      send_word(CMD_SEARCH, 32'h7FFF_FFFF, $urandom);
      send_word(CMD_SEARCH, 32'h8000_0001, $urandom);
      send_word(CMD_INSERT, 32'h8000_0001, 32'hAAAA_AAAA);
      send_word(CMD_REMOVE, 32'h0000_0000, $urandom);
      send_word(CMD_SEARCH, 32'hFFFF_FC00, $urandom);
      send_word(CMD_INSERT, 32'hFFFF_FC00, $urandom);
      send_word(CMD_INSERT, 32'h0000_0800, $urandom);
      send_word(CMD_REMOVE, 32'h0000_0000, $urandom);
      send_word(CMD_REMOVE, 32'h8000_0001, $urandom);
      send_word(CMD_SEARCH, 32'h8000_0001, $urandom);
      send_word(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_SEARCH, 32'h0000_0800, $urandom);
      write_limit(0);
      send_word(CMD_INSERT, 32'h0000_0001, $urandom);
      write_limit(2);
      send_word(CMD_INSERT, 32'h0000_0005, $urandom);
      send_word(CMD_INSERT, 32'hFFFF_FFFB, $urandom);
      send_word(CMD_INSERT, 32'h0000_0005, $urandom);
      send_word(CMD_SEARCH, 32'hFFFF_FFFB, $urandom);
   endtask

   task automatic run_mix(input int count, input int lim);
      int          i;
      int          h;
      int          pick;
      logic [1:0]  cmd;
      logic [31:0] key;
      write_limit(lim);
      key_pool.delete();
      for (i = 0; i < 4; i++) begin
         h = (i == 0) ? $urandom_range(TABLE_SIZE - 1, TABLE_SIZE - 3)
                      : $urandom_range(TABLE_SIZE - 1);
         repeat (8) key_pool.push_back(key_at_home(h));
      end
      key_pool.push_back(32'h8000_0000);
      key_pool.push_back(32'h7FFF_FFFF);
      send_word(CMD_CLEAR, $urandom, $urandom);
      for (i = 1; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 2) cmd = CMD_CLEAR;
         else if (pick < 45) cmd = CMD_INSERT;
         else if (pick < 72) cmd = CMD_SEARCH;
         else cmd = CMD_REMOVE;
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(key_pool.size() - 1)];
         else key = $urandom;
         send_word(cmd, key, $urandom);
      end
   endtask

   task automatic run_fill();
      int          homes [TABLE_SIZE];
      int          i;
      int          j;
      int          tmp;
      logic [31:0] key;
      write_limit(2047);
      send_word(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
      for (i = 0; i < TABLE_SIZE; i++) homes[i] = i;
      for (i = TABLE_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = homes[i];
         homes[i] = homes[j];
         homes[j] = tmp;
      end
      fill_keys.delete();
      for (i = 0; i < TABLE_SIZE; i++) begin
         key = key_at_home(homes[i]);
         fill_keys.push_back(key);
         send_word(CMD_INSERT, key, $urandom);
      end
      send_word(CMD_INSERT, $urandom, $urandom);
      send_word(CMD_SEARCH, $urandom, $urandom);
      for (i = 0; i < 30; i++) begin
         key = fill_keys[$urandom_range(TABLE_SIZE - 1)];
         case ($urandom_range(4))
            0: send_word(CMD_INSERT, $urandom, $urandom);
            1: send_word(CMD_INSERT, key, $urandom);
            2: send_word(CMD_SEARCH, key, $urandom);
            3: send_word(CMD_SEARCH, $urandom, $urandom);
            default: send_word(CMD_REMOVE, key, $urandom);
         endcase
      end
   endtask

   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
            board.check_status(rsp_word);
            words_checked++;
         end
         if (!hold_done && words_checked == 100) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_word <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_mix(200, 16);
      run_mix(60, 1);
      run_fill();
      run_mix(90, 1024);
      drain();
      repeat (1100) @(posedge clock);
      if (board.mismatches == 0 && board.expected_status.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_front.sv
hdl/lpht_back.sv
hdl/linear_probe_hash_table_unit.sv
dv/testbench.sv
